// ===== rtl/p2qe_pkg.sv =====
// Shared types, constants and helpers for the P-square quantile estimator.
// No dependencies; every other module of the block imports this package.
`default_nettype none

package p2qe_pkg;

  // Fixed field widths of the ports
  localparam int FIELD_W   = 32;
  localparam int P_W       = 16;
  localparam int DES_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int WIDE_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 2;

  localparam logic [DES_W-1:0] ONE_Q16 = 48'd65536;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_P  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H4 = 3'd5;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CELL,
    OP_EVAL,
    OP_TERM1,
    OP_TERM2,
    OP_DIVS,
    OP_LIN,
    OP_COMMIT,
    OP_OUTPUT
  } p2qe_op_e;

  typedef struct packed {
    logic             take;   // input transfer this cycle
    p2qe_op_e         op;
    logic             start;  // launch the term unit
    logic [IDX_W-1:0] idx;    // inner marker under adjustment
  } p2qe_cmd_t;

  typedef struct packed {
    logic go;        // marker must move
    logic ok;        // parabolic prediction lies between neighbors
    logic done;      // term unit result ready
    logic out_free;  // output register can take a result
  } p2qe_sts_t;

  // 64-bit saturating add
  function automatic logic signed [WIDE_W-1:0] sat_add(
    input logic signed [WIDE_W-1:0] a,
    input logic signed [WIDE_W-1:0] b
  );
    logic signed [WIDE_W-1:0] sum;
    sum = a + b;
    if ((a[WIDE_W-1] == b[WIDE_W-1]) && (sum[WIDE_W-1] != a[WIDE_W-1])) begin
      sum = a[WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/p2qe_term.sv =====
// Sequential scaled-term unit: trunc(a*b/c) with sign, saturated to 63 bits.
// Shift-add multiply, then restoring radix-2 divide. Uses p2qe_pkg.
`default_nettype none

module p2qe_term
  import p2qe_pkg::*;
#(
  parameter int AW = 33,
  parameter int CW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     zero_i,
  input  logic                     neg_i,
  input  logic [AW-1:0]            a_i,
  input  logic [WIDE_W-1:0]        b_i,
  input  logic [CW-1:0]            c_i,
  output logic                     done_o,
  output logic signed [WIDE_W-1:0] res_o
);

  localparam int PW    = AW + WIDE_W;
  localparam int QW    = WIDE_W - 1;
  localparam int HW    = PW - QW;
  localparam int CNT_W = $clog2((AW > QW) ? AW : QW);

  typedef enum logic [2:0] {T_IDLE, T_MUL, T_SAT, T_DIV, T_DONE} term_state_e;

  term_state_e      st_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    a_q;
  logic [WIDE_W-1:0] b_q;
  logic [CW-1:0]    c_q;
  logic             neg_q;
  logic [PW-1:0]    prod_q;
  logic [CW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;

  logic [HW-1:0]    hi;
  logic [CW:0]      r2;
  logic [CW:0]      r2_sub;
  logic             qbit;
  logic [WIDE_W-1:0] mag;

  assign hi     = prod_q[PW-1:QW];
  assign r2     = {rem_q, quo_q[QW-1]};
  assign qbit   = (r2 >= {1'b0, c_q});
  assign r2_sub = r2 - {1'b0, c_q};
  assign mag    = {1'b0, quo_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= T_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        T_IDLE: begin
          if (start_i) begin
            if (zero_i) st_q <= T_DONE;
            else if (a_i == AW'(1)) st_q <= T_SAT;
            else begin
              st_q  <= T_MUL;
              cnt_q <= CNT_W'(AW - 1);
            end
          end
        end
        T_MUL: begin
          if (cnt_q == '0) st_q <= T_SAT;
          else cnt_q <= cnt_q - 1'b1;
        end
        T_SAT: begin
          if (hi >= HW'(c_q)) st_q <= T_DONE;
          else begin
            st_q  <= T_DIV;
            cnt_q <= CNT_W'(QW - 1);
          end
        end
        T_DIV: begin
          if (cnt_q == '0) st_q <= T_DONE;
          else cnt_q <= cnt_q - 1'b1;
        end
        T_DONE:  st_q <= T_IDLE;
        default: st_q <= T_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      T_IDLE: begin
        if (start_i) begin
          a_q    <= a_i;
          b_q    <= b_i;
          c_q    <= c_i;
          neg_q  <= neg_i;
          quo_q  <= '0;
          prod_q <= (a_i == AW'(1)) ? PW'(b_i) : '0;
        end
      end
      T_MUL: begin
        prod_q <= (prod_q << 1) + (a_q[AW-1] ? PW'(b_q) : '0);
        a_q    <= a_q << 1;
      end
      T_SAT: begin
        // quotient would not fit 63 bits: saturate
        if (hi >= HW'(c_q)) quo_q <= '1;
        else begin
          rem_q <= hi[CW-1:0];
          quo_q <= prod_q[QW-1:0];
        end
      end
      T_DIV: begin
        rem_q <= qbit ? r2_sub[CW-1:0] : r2[CW-1:0];
        quo_q <= {quo_q[QW-2:0], qbit};
      end
      default: ;
    endcase
  end

  assign done_o = (st_q == T_DONE);
  assign res_o  = neg_q ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// ===== rtl/p2qe_dpath.sv =====
// Datapath: configuration, marker state, term unit and output register.
// Uses p2qe_pkg and p2qe_term; driven by p2qe_ctrl commands.
`default_nettype none

module p2qe_dpath
  import p2qe_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  p2qe_cmd_t                 cmd_i,
  output p2qe_sts_t                 sts_o,
  input  logic signed [FIELD_W-1:0] sample_i,
  input  logic                      cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FIELD_W-1:0]        cfg_data_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [FIELD_W-1:0] estimate_o,
  output logic signed [FIELD_W-1:0] minimum_seen_o,
  output logic signed [FIELD_W-1:0] maximum_seen_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COUNT_WIDTH;
  localparam int AW = CW + 1;
  localparam int NW = ((CW > 32) ? CW : 32) + 1;

  localparam logic signed [CW+1:0] PLUS1  = (CW+2)'(1);
  localparam logic signed [CW+1:0] MINUS1 = -(CW+2)'(1);
  localparam logic signed [CW:0]   ONE_C  = (CW+1)'(1);

  // Configuration registers
  logic [P_W-1:0]     p_q;
  logic [FIELD_W-1:0] init_q [5];

  // Marker state
  logic signed [SW-1:0] q_q   [5];
  logic [CW-1:0]        n_q   [5];
  logic [DES_W-1:0]     des_q [5];
  logic                 loaded_q;
  logic [FIELD_W-1:0]   x_q;

  // Working registers
  logic                     up_q;
  logic signed [WIDE_W-1:0] t1_q;
  logic signed [WIDE_W-1:0] s_q;
  logic signed [WIDE_W-1:0] qn_q;

  // Output register
  logic                      out_valid_q;
  logic signed [FIELD_W-1:0] est_q;
  logic signed [FIELD_W-1:0] min_q;
  logic signed [FIELD_W-1:0] max_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q       <= 16'd32768;
      init_q[0] <= 32'd1311;
      init_q[1] <= 32'd9830;
      init_q[2] <= 32'd48497;
      init_q[3] <= 32'd54395;
      init_q[4] <= 32'd222167;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_P:   p_q       <= cfg_data_i[P_W-1:0];
        REG_H0:  init_q[0] <= cfg_data_i;
        REG_H1:  init_q[1] <= cfg_data_i;
        REG_H2:  init_q[2] <= cfg_data_i;
        REG_H3:  init_q[3] <= cfg_data_i;
        REG_H4:  init_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cell step: effective state, cell search, increments
  logic [DES_W-1:0]     p48;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] qe [5];
  logic [DES_W-1:0]     de [5];
  logic [DES_W-1:0]     dinit [5];
  logic [DES_W-1:0]     inc [5];
  logic [1:0]           k;
  logic                 lo_set, hi_set;

  assign p48 = DES_W'(p_q);
  assign xs  = SW'(x_q);

  assign dinit[0] = ONE_Q16;
  assign dinit[1] = ONE_Q16 + (p48 << 1);
  assign dinit[2] = ONE_Q16 + (p48 << 2);
  assign dinit[3] = (ONE_Q16 << 1) + ONE_Q16 + (p48 << 1);
  assign dinit[4] = (ONE_Q16 << 2) + ONE_Q16;

  assign inc[0] = '0;
  assign inc[1] = p48 >> 1;
  assign inc[2] = p48;
  assign inc[3] = (p48 + ONE_Q16) >> 1;
  assign inc[4] = ONE_Q16;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      qe[i] = loaded_q ? q_q[i] : SW'(init_q[i]);
      de[i] = loaded_q ? des_q[i] : dinit[i];
    end
  end

  always_comb begin
    k      = 2'd0;
    lo_set = 1'b0;
    hi_set = 1'b0;
    if (xs >= qe[2]) begin
      if (xs < qe[3]) k = 2'd2;
      else begin
        k      = 2'd3;
        hi_set = (xs > qe[4]);
      end
    end else begin
      if (xs >= qe[1]) k = 2'd1;
      else begin
        k      = 2'd0;
        lo_set = (xs < qe[0]);
      end
    end
  end

  // Window around the marker under adjustment
  logic signed [SW-1:0] q_lo, q_mid, q_hi;
  logic [CW-1:0]        n_lo, n_mid, n_hi;
  logic [DES_W-1:0]     des_mid;

  always_comb begin
    case (cmd_i.idx)
      2'd2: begin
        q_lo = q_q[1]; q_mid = q_q[2]; q_hi = q_q[3];
        n_lo = n_q[1]; n_mid = n_q[2]; n_hi = n_q[3];
        des_mid = des_q[2];
      end
      2'd3: begin
        q_lo = q_q[2]; q_mid = q_q[3]; q_hi = q_q[4];
        n_lo = n_q[2]; n_mid = n_q[3]; n_hi = n_q[4];
        des_mid = des_q[3];
      end
      default: begin
        q_lo = q_q[0]; q_mid = q_q[1]; q_hi = q_q[2];
        n_lo = n_q[0]; n_mid = n_q[1]; n_hi = n_q[2];
        des_mid = des_q[1];
      end
    endcase
  end

  // Position differences and move decision
  logic signed [CW:0] dl, dr, dt, dn;
  logic [NW-1:0]      ipw, nw;
  logic [FRAC_W-1:0]  fr;
  logic               up, down;

  assign dl  = $signed({1'b0, n_mid}) - $signed({1'b0, n_lo});
  assign dr  = $signed({1'b0, n_hi}) - $signed({1'b0, n_mid});
  assign dt  = $signed({1'b0, n_hi}) - $signed({1'b0, n_lo});
  assign dn  = up_q ? dr : -dl;
  assign ipw = NW'(des_mid[DES_W-1:FRAC_W]);
  assign fr  = des_mid[FRAC_W-1:0];
  assign nw  = NW'(n_mid);
  assign up  = (ipw >= nw + NW'(1));
  assign down = (n_mid != '0) &&
                ((ipw < nw - NW'(1)) || ((ipw == nw - NW'(1)) && (fr == '0)));

  // Operand magnitudes and signs
  logic signed [CW+1:0] dstep, cnt1, cnt2, ncnt1, ncnt2;
  logic [AW-1:0]        a1, a2;
  logic signed [SW:0]   hd_hi, hd_lo, hd_ln, nhd_hi, nhd_lo, nhd_ln;
  logic [SW-1:0]        m_hi, m_lo, m_ln;
  logic signed [CW:0]   ndl, ndr, ndt, ndn;
  logic [CW-1:0]        c_dl, c_dr, c_dt, c_dn;
  logic signed [WIDE_W-1:0] ns;
  logic [WIDE_W-1:0]    s_mag;
  logic signed [SW-1:0] q_tgt;

  assign dstep = up_q ? PLUS1 : MINUS1;
  assign cnt1  = $signed({dl[CW], dl}) + dstep;
  assign cnt2  = $signed({dr[CW], dr}) - dstep;
  assign ncnt1 = -cnt1;
  assign ncnt2 = -cnt2;
  assign a1    = cnt1[CW+1] ? ncnt1[CW:0] : cnt1[CW:0];
  assign a2    = cnt2[CW+1] ? ncnt2[CW:0] : cnt2[CW:0];

  assign q_tgt  = up_q ? q_hi : q_lo;
  assign hd_hi  = $signed({q_hi[SW-1], q_hi}) - $signed({q_mid[SW-1], q_mid});
  assign hd_lo  = $signed({q_mid[SW-1], q_mid}) - $signed({q_lo[SW-1], q_lo});
  assign hd_ln  = $signed({q_tgt[SW-1], q_tgt}) - $signed({q_mid[SW-1], q_mid});
  assign nhd_hi = -hd_hi;
  assign nhd_lo = -hd_lo;
  assign nhd_ln = -hd_ln;
  assign m_hi   = hd_hi[SW] ? nhd_hi[SW-1:0] : hd_hi[SW-1:0];
  assign m_lo   = hd_lo[SW] ? nhd_lo[SW-1:0] : hd_lo[SW-1:0];
  assign m_ln   = hd_ln[SW] ? nhd_ln[SW-1:0] : hd_ln[SW-1:0];

  assign ndl  = -dl;
  assign ndr  = -dr;
  assign ndt  = -dt;
  assign ndn  = -dn;
  assign c_dl = dl[CW] ? ndl[CW-1:0] : dl[CW-1:0];
  assign c_dr = dr[CW] ? ndr[CW-1:0] : dr[CW-1:0];
  assign c_dt = dt[CW] ? ndt[CW-1:0] : dt[CW-1:0];
  assign c_dn = dn[CW] ? ndn[CW-1:0] : dn[CW-1:0];

  assign ns    = -s_q;
  assign s_mag = s_q[WIDE_W-1] ? ns : s_q;

  // Term unit operand select
  logic                     t_zero, t_neg, t_done;
  logic [AW-1:0]            t_a;
  logic [WIDE_W-1:0]        t_b;
  logic [CW-1:0]            t_c;
  logic signed [WIDE_W-1:0] t_res;

  always_comb begin
    case (cmd_i.op)
      OP_TERM1: begin
        t_a = a1; t_b = WIDE_W'(m_hi); t_c = c_dr;
        t_neg = cnt1[CW+1] ^ hd_hi[SW] ^ dr[CW];
        t_zero = (dr == '0);
      end
      OP_TERM2: begin
        t_a = a2; t_b = WIDE_W'(m_lo); t_c = c_dl;
        t_neg = cnt2[CW+1] ^ hd_lo[SW] ^ dl[CW];
        t_zero = (dl == '0);
      end
      OP_DIVS: begin
        t_a = AW'(1); t_b = s_mag; t_c = c_dt;
        t_neg = s_q[WIDE_W-1] ^ dt[CW];
        t_zero = (dt == '0);
      end
      default: begin
        t_a = AW'(1); t_b = WIDE_W'(m_ln); t_c = c_dn;
        t_neg = (!up_q) ^ hd_ln[SW] ^ dn[CW];
        t_zero = (dn == '0);
      end
    endcase
  end

  p2qe_term #(
    .AW (AW),
    .CW (CW)
  ) u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .zero_i  (t_zero),
    .neg_i   (t_neg),
    .a_i     (t_a),
    .b_i     (t_b),
    .c_i     (t_c),
    .done_o  (t_done),
    .res_o   (t_res)
  );

  logic signed [WIDE_W-1:0] qm64, ql64, qh64, t_sgn;

  assign qm64  = WIDE_W'(q_mid);
  assign ql64  = WIDE_W'(q_lo);
  assign qh64  = WIDE_W'(q_hi);
  assign t_sgn = up_q ? t_res : -t_res;

  // Control state of the datapath: load flag, positions, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 5; i++) n_q[i] <= CW'(i + 1);
    end else begin
      if (cmd_i.op == OP_OUTPUT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CELL: begin
          loaded_q <= 1'b1;
          for (int i = 1; i < 5; i++) begin
            if (3'(i) > {1'b0, k}) n_q[i] <= n_q[i] + 1'b1;
          end
        end
        OP_COMMIT: begin
          for (int i = 1; i < 4; i++) begin
            if (cmd_i.idx == IDX_W'(i)) n_q[i] <= up_q ? n_q[i] + 1'b1 : n_q[i] - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) x_q <= sample_i;
    case (cmd_i.op)
      OP_CELL: begin
        for (int i = 0; i < 5; i++) begin
          q_q[i]   <= qe[i];
          des_q[i] <= de[i] + inc[i];
        end
        if (lo_set) q_q[0] <= xs;
        if (hi_set) q_q[4] <= xs;
      end
      OP_EVAL: up_q <= up;
      OP_TERM1: if (t_done) t1_q <= t_res;
      OP_TERM2: if (t_done) s_q <= sat_add(t1_q, t_res);
      OP_DIVS:  if (t_done) qn_q <= sat_add(qm64, t_sgn);
      OP_LIN:   if (t_done) qn_q <= sat_add(qm64, t_res);
      OP_COMMIT: begin
        for (int i = 1; i < 4; i++) begin
          if (cmd_i.idx == IDX_W'(i)) q_q[i] <= qn_q[SW-1:0];
        end
      end
      OP_OUTPUT: begin
        est_q <= FIELD_W'(q_q[2]);
        min_q <= FIELD_W'(q_q[0]);
        max_q <= FIELD_W'(q_q[4]);
      end
      default: ;
    endcase
  end

  assign sts_o.go       = (up && (dr > ONE_C)) || (down && (dl > ONE_C));
  assign sts_o.ok       = (qn_q > ql64) && (qn_q < qh64);
  assign sts_o.done     = t_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign estimate_o     = est_q;
  assign minimum_seen_o = min_q;
  assign maximum_seen_o = max_q;

endmodule

`default_nettype wire

// ===== rtl/p2qe_ctrl.sv =====
// Controller: sequences the cell step and the three inner-marker adjustments.
// Uses p2qe_pkg; drives p2qe_dpath through command and status structs.
`default_nettype none

module p2qe_ctrl
  import p2qe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output p2qe_cmd_t cmd_o,
  input  p2qe_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CELL, S_EVAL, S_T1, S_T1W, S_T2, S_T2W,
    S_DV, S_DVW, S_CHK, S_LN, S_LNW, S_COMMIT, S_OUT
  } ctrl_state_e;

  ctrl_state_e      state_q;
  logic [IDX_W-1:0] idx_q;

  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(3);

  // State and marker index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= IDX_FIRST;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CELL;
        S_CELL: begin
          state_q <= S_EVAL;
          idx_q   <= IDX_FIRST;
        end
        S_EVAL: begin
          if (sts_i.go) state_q <= S_T1;
          else if (idx_q == IDX_LAST) state_q <= S_OUT;
          else idx_q <= idx_q + 1'b1;
        end
        S_T1:  state_q <= S_T1W;
        S_T1W: if (sts_i.done) state_q <= S_T2;
        S_T2:  state_q <= S_T2W;
        S_T2W: if (sts_i.done) state_q <= S_DV;
        S_DV:  state_q <= S_DVW;
        S_DVW: if (sts_i.done) state_q <= S_CHK;
        S_CHK: state_q <= sts_i.ok ? S_COMMIT : S_LN;
        S_LN:  state_q <= S_LNW;
        S_LNW: if (sts_i.done) state_q <= S_COMMIT;
        S_COMMIT: begin
          if (idx_q == IDX_LAST) state_q <= S_OUT;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_EVAL;
          end
        end
        S_OUT:   if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o.take  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.idx   = idx_q;
    cmd_o.start = (state_q == S_T1) || (state_q == S_T2) ||
                  (state_q == S_DV) || (state_q == S_LN);
    case (state_q)
      S_CELL:          cmd_o.op = OP_CELL;
      S_EVAL:          cmd_o.op = OP_EVAL;
      S_T1, S_T1W:     cmd_o.op = OP_TERM1;
      S_T2, S_T2W:     cmd_o.op = OP_TERM2;
      S_DV, S_DVW:     cmd_o.op = OP_DIVS;
      S_LN, S_LNW:     cmd_o.op = OP_LIN;
      S_COMMIT:        cmd_o.op = OP_COMMIT;
      S_OUT:           cmd_o.op = sts_i.out_free ? OP_OUTPUT : OP_NONE;
      default:         cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  // term unit finishes only while a wait state expects it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> (state_q == S_T1W || state_q == S_T2W ||
                    state_q == S_DVW || state_q == S_LNW))
    else $error("term result outside a wait state");

  // only inner markers are adjusted
  a_idx_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (idx_q != '0))
    else $error("marker index out of range");

  // after a commit the next marker is evaluated or the result goes out
  a_commit_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> (state_q == S_EVAL || state_q == S_OUT))
    else $error("bad sequence after commit");

  // the output register is loaded only when it is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUTPUT) |-> sts_i.out_free)
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/p2_quantile_estimator.sv =====
// Each moving marker runs two multiply-divide terms, one division and a possible linear
// step on the shared radix-2 term unit. A new sample is taken only after the last result
// enters the output register, in the cycle after it does. Reset: asynchronous, positions
// 1..5, registers to defaults; the first sample reloads heights and desired positions.
`default_nettype none

module p2_quantile_estimator
  import p2qe_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FIELD_W-1:0] estimate_o,
  output logic signed [FIELD_W-1:0] minimum_seen_o,
  output logic signed [FIELD_W-1:0] maximum_seen_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FIELD_W-1:0]        cfg_data_i
);

  p2qe_cmd_t cmd;
  p2qe_sts_t sts;

  // configuration is always accepted
  assign cfg_ready_o = 1'b1;

  p2qe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  p2qe_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .estimate_o     (estimate_o),
    .minimum_seen_o (minimum_seen_o),
    .maximum_seen_o (maximum_seen_o)
  );

endmodule

`default_nettype wire

// ===== tb/p2qe_checker.sv =====
// Scoreboard for the P-square quantile estimator: tracks config and sample transfers,
// runs its own copy of the estimator and compares every result. Uses p2qe_pkg.
`default_nettype none

module p2qe_checker
  import p2qe_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [FIELD_W-1:0] sample_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [FIELD_W-1:0] estimate_i,
  input  logic signed [FIELD_W-1:0] minimum_seen_i,
  input  logic signed [FIELD_W-1:0] maximum_seen_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FIELD_W-1:0]        cfg_data_i,
  output int                        errors_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [31:0] est;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } summary_t;

  summary_t                 summary_q[$];
  logic [15:0]              p_reg;
  logic [31:0]              h_reg[5];
  logic signed [63:0]       height[5];
  logic [31:0]              pos[5];
  logic [47:0]              want[5];
  logic                     primed;

  assign pending_o = summary_q.size();

  // trunc(cnt*(qa-qb)/dv), 128-bit exact, magnitude capped at 2^63-1
  function automatic logic signed [63:0] scaled(input logic signed [63:0] cnt,
    input logic signed [63:0] qa, input logic signed [63:0] qb,
    input logic signed [63:0] dv);
    logic [63:0]  cm, hm, dm;
    logic [127:0] prod, quo;
    logic         neg;
    logic [63:0]  mag;
    if (dv == 0 || cnt == 0 || qa == qb) return 0;
    neg = 0;
    if (cnt < 0) begin cm = -cnt; neg = ~neg; end else cm = cnt;
    if (qa < qb) begin hm = qb - qa; neg = ~neg; end else hm = qa - qb;
    if (dv < 0) begin dm = -dv; neg = ~neg; end else dm = dv;
    prod = {64'd0, cm} * {64'd0, hm};
    quo = prod / {64'd0, dm};
    mag = (quo > 128'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : quo[63:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
    input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? WIDE_MIN : WIDE_MAX;
    return s;
  endfunction

  task automatic reload();
    for (int i = 0; i < 5; i++) height[i] = $signed(h_reg[i]);
    want[0] = ONE_Q16;
    want[1] = ONE_Q16 + 2 * p_reg;
    want[2] = ONE_Q16 + 4 * p_reg;
    want[3] = 3 * ONE_Q16 + 2 * p_reg;
    want[4] = 5 * ONE_Q16;
  endtask

  // One estimator step: returns the summary after the sample
  task automatic estimate_step(input logic signed [31:0] smp, output summary_t res);
    logic signed [63:0] x, dl, dr, dt, d, s, q1, dn, lin;
    logic [47:0]        inc[5];
    logic [31:0]        ip;
    logic [15:0]        fr;
    logic               up, dnw;
    int                 k;
    if (!primed) begin reload(); primed = 1; end
    x = smp;
    if (x >= height[2]) begin
      if (x < height[3]) k = 2;
      else begin k = 3; if (x > height[4]) height[4] = x; end
    end else begin
      if (x >= height[1]) k = 1;
      else begin k = 0; if (x < height[0]) height[0] = x; end
    end
    for (int i = k + 1; i < 5; i++) pos[i] = pos[i] + 1;
    inc[0] = 0;
    inc[1] = p_reg >> 1;
    inc[2] = p_reg;
    inc[3] = ({32'd0, p_reg} + ONE_Q16) >> 1;
    inc[4] = ONE_Q16;
    for (int i = 0; i < 5; i++) want[i] = want[i] + inc[i];
    // inner marker adjustment, in order 1..3
    for (int i = 1; i <= 3; i++) begin
      ip = want[i] >> 16;
      fr = want[i][15:0];
      dl = $signed({32'd0, pos[i]}) - $signed({32'd0, pos[i-1]});
      dr = $signed({32'd0, pos[i+1]}) - $signed({32'd0, pos[i]});
      dt = $signed({32'd0, pos[i+1]}) - $signed({32'd0, pos[i-1]});
      up = {1'b0, ip} >= {1'b0, pos[i]} + 33'd1;
      dnw = pos[i] >= 1 && ({1'b0, ip} < {1'b0, pos[i]} - 33'd1 ||
            ({1'b0, ip} == {1'b0, pos[i]} - 33'd1 && fr == 0));
      if ((up && dr > 1) || (dnw && dl > 1)) begin
        d = up ? 1 : -1;
        s = add_sat(scaled(dl + d, height[i+1], height[i], dr),
                    scaled(dr - d, height[i], height[i-1], dl));
        q1 = (dt == 0) ? height[i] : add_sat(height[i], (s / dt) * d);
        if (q1 > height[i-1] && q1 < height[i+1]) height[i] = q1;
        else begin
          dn = up ? dr : -dl;
          lin = scaled(d, up ? height[i+1] : height[i-1], height[i], dn);
          height[i] = $signed(add_sat(height[i], lin)) <<< 32 >>> 32;
        end
        pos[i] = up ? pos[i] + 1 : pos[i] - 1;
      end
    end
    res.est = height[2][31:0];
    res.lo = height[0][31:0];
    res.hi = height[4][31:0];
  endtask

  // Track config writes, sample transfers and results
  always @(posedge clk_i or negedge rst_ni) begin
    summary_t nxt, got, exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
      summary_q.delete();
      p_reg = 16'd32768;
      h_reg[0] = 1311; h_reg[1] = 9830; h_reg[2] = 48497;
      h_reg[3] = 54395; h_reg[4] = 222167;
      for (int i = 0; i < 5; i++) pos[i] = i + 1;
      primed = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_P) p_reg = cfg_data_i[15:0];
        else if (cfg_index_i <= REG_H4) h_reg[cfg_index_i - 1] = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        estimate_step(sample_i, nxt);
        summary_q.push_back(nxt);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{estimate_i, minimum_seen_i, maximum_seen_i};
        if (summary_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = summary_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch est exp %h got %h | min exp %h got %h | max exp %h got %h",
                     $time, exp_r.est, got.est, exp_r.lo, got.lo, exp_r.hi, got.hi);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/p2_quantile_estimator_tb.sv =====
// Top of the estimator testbench: clock, reset, config phases, sample stimulus and
// verdict. Depends on p2qe_pkg, p2_quantile_estimator and p2qe_checker.
`default_nettype none

module p2_quantile_estimator_tb;
  import p2qe_pkg::*;

  localparam int WATCHDOG = 20000;

  logic                      clk_i = 0;
  logic                      rst_ni = 0;
  logic                      in_valid_i = 0;
  logic                      in_stall_o;
  logic signed [FIELD_W-1:0] sample_i = 0;
  logic                      out_valid_o;
  logic                      out_stall_i = 0;
  logic signed [FIELD_W-1:0] estimate_o, minimum_seen_o, maximum_seen_o;
  logic                      cfg_valid_i = 0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = 0;
  logic [FIELD_W-1:0]        cfg_data_i = 0;
  int                        errors, pending, idle_cycles;
  logic                      calm;

  always #6 clk_i = ~clk_i;

  p2_quantile_estimator DUT (.*);

  p2qe_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .estimate_i(estimate_o),
    .minimum_seen_i(minimum_seen_o), .maximum_seen_i(maximum_seen_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver stalls in about 7% of cycles unless in a calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays high after the transfer; the caller drops it when done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // valid drops only while idling or draining
  task automatic send_sample(input logic [31:0] val);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    sample_i   <= val;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  // Random sample: mostly a spread around the markers, sometimes extremes
  function automatic logic [31:0] rand_sample(input int spread);
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(2 * spread)) - spread;
    endcase
  endfunction

  initial begin
    logic [31:0] h;
    calm = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, extremes, ties and outside samples
    send_sample(32'h80000000);
    send_sample(32'h7FFFFFFF);
    send_sample(32'd48497);
    send_sample(32'd222167);
    send_sample(32'd9830);
    send_sample(32'd0);
    send_sample(32'hFFFFFFFF);
    send_sample(32'h55555555);
    send_sample(32'hAAAAAAAA);
    for (int i = 0; i < 10; i++) send_sample(i * 20000);
    drain();

    // Several settings: extremes of p, descending and extreme heights, unlisted index
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(REG_P, 32'd1);
        1: write_reg(REG_P, 32'd65535);
        2: write_reg(REG_P, 32'd16384);
        default: write_reg(REG_P, $urandom_range(65535, 1));
      endcase
      for (int r = 0; r < 5; r++) begin
        case (ph)
          1: h = (r == 0) ? 32'h80000000 : (r == 4) ? 32'h7FFFFFFF : r * 1000;
          2: h = (4 - r) * 65536;
          default: h = $signed($urandom_range(400000)) - 200000 + r * 50000;
        endcase
        write_reg(CFG_IDX_W'(REG_H0 + r), h);
      end
      write_reg(3'd6 + ph[0], $urandom);
      cfg_valid_i <= 0;
      calm = (ph == 3);
      for (int i = 0; i < 105; i++)
        send_sample(rand_sample(ph == 1 ? 30000 : 400000));
      calm = 0;
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
